// ===== rtl/rnmu_pkg.sv =====
// Shared types, constants and register map of the refractory neuron membrane update.
package rnmu_pkg;

   localparam int unsigned NUM_EXC          = 2;
   localparam int unsigned NUM_INH          = 2;
   localparam int unsigned REFRACTORY_TICKS = 4;

   localparam int unsigned WORD_W    = 32;
   localparam int unsigned FRAC_W    = 15;
   localparam int unsigned COUNT_W   = 8;
   localparam int unsigned REG_COUNT = 8;
   localparam int unsigned REG_IDX_W = $clog2(REG_COUNT);
   localparam int unsigned ADDR_W    = REG_IDX_W + 2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // register indexes
   localparam logic [REG_IDX_W-1:0] REG_REST_BIAS    = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_REST_INV     = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_REST_DECAY   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_SPIKE_BIAS   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_SPIKE_INV    = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_SPIKE_DECAY  = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_TIME_SCALE   = 3'd6;
   localparam logic [REG_IDX_W-1:0] REG_RESET_VOLT   = 3'd7;

   // command codes
   localparam logic CMD_TIMESTEP = 1'b0;
   localparam logic CMD_SPIKE    = 1'b1;

   typedef logic signed [WORD_W-1:0] word_type;

   localparam word_type REG_RESET [REG_COUNT] = '{
      32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd32768, 32'sd0
   };

   typedef struct packed {
      logic     command;
      word_type exc_current_0;
      word_type exc_current_1;
      word_type inh_current_0;
      word_type inh_current_1;
      word_type bias_current;
   } req_item_type;

   typedef struct packed {
      word_type membrane_voltage_out;
      logic     refractory_active;
   } rsp_item_type;

   typedef struct packed {
      word_type rest_bias;
      word_type rest_inverse_gain;
      word_type rest_decay;
      word_type spike_bias;
      word_type spike_inverse_gain;
      word_type spike_decay;
      word_type input_time_scale;
      word_type reset_voltage;
   } cfg_type;

endpackage

// ===== rtl/refractory_neuron_membrane_update.sv =====
// Top level: sequencer, neuron state and result register of the membrane update.
// Timestep word: steps MUL1, MUL2, MUL3, ADD, DONE; the result register loads from DONE;
//    the one shared multiplier runs drive*scale, (bias+p)*inverse gain, (V-k)*decay.
// Spike word: goes straight to DONE. A new word is taken only once the sequencer is idle again.
// A stalled result holds the sequencer in its last step until the word is taken.
// Reset (synchronous, active high) clears state and result valid, loads register defaults.
module refractory_neuron_membrane_update (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  rnmu_pkg::req_item_type      req_item,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output rnmu_pkg::rsp_item_type      rsp_item,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [rnmu_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);
   import rnmu_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL1 = 3'd1;
   localparam logic [2:0] S_MUL2 = 3'd2;
   localparam logic [2:0] S_MUL3 = 3'd3;
   localparam logic [2:0] S_ADD  = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   cfg_type cfg;

   logic [2:0]         state_ff, state_in;
   word_type           volt_ff, volt_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               phase_ff, phase_in;
   word_type           drive_ff, drive_in;
   word_type           k_ff, k_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_item_ff;
   logic               rsp_load;

   logic               accept;
   word_type           drive_sum;
   word_type           exc_extra, inh_extra;
   logic [COUNT_W:0]   count_sum;
   word_type           bias_sel, inv_sel, decay_sel;
   word_type           op_a, op_b, product;

   rnmu_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rnmu_mul_unit u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .product (product)
   );

   // Take a word only when the sequencer is idle.
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   // Drive current: only the configured number of current inputs take part.
   assign exc_extra = (NUM_EXC >= 2) ? req_item.exc_current_1 : '0;
   assign inh_extra = (NUM_INH >= 2) ? req_item.inh_current_1 : '0;
   assign drive_sum = req_item.exc_current_0 + exc_extra
                    - req_item.inh_current_0 - inh_extra + req_item.bias_current;

   // Saturating add of the refractory length.
   assign count_sum = {1'b0, count_ff} + (COUNT_W+1)'(REFRACTORY_TICKS);

   // Phase constants, selected by the phase latched at acceptance.
   assign bias_sel  = phase_ff ? cfg.spike_bias         : cfg.rest_bias;
   assign inv_sel   = phase_ff ? cfg.spike_inverse_gain : cfg.rest_inverse_gain;
   assign decay_sel = phase_ff ? cfg.spike_decay        : cfg.rest_decay;

   // Steer the shared multiplier for each step.
   always_comb begin
      op_a = drive_ff;
      op_b = cfg.input_time_scale;
      case (state_ff)
         S_MUL2: begin
            op_a = bias_sel + product;
            op_b = inv_sel;
         end
         S_MUL3: begin
            op_a = volt_ff - product;
            op_b = decay_sel;
         end
         default: begin
            op_a = drive_ff;
            op_b = cfg.input_time_scale;
         end
      endcase
   end

   // Result word goes out when the output register is free or being emptied.
   assign rsp_load = (state_ff == S_DONE) && !(rsp_valid_ff && rsp_stall);

   always_comb begin
      state_in     = state_ff;
      volt_in      = volt_ff;
      count_in     = count_ff;
      phase_in     = phase_ff;
      drive_in     = drive_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_item.command == CMD_SPIKE) begin
                  volt_in  = cfg.reset_voltage;
                  count_in = count_sum[COUNT_W] ? COUNT_MAX : count_sum[COUNT_W-1:0];
                  state_in = S_DONE;
               end else begin
                  drive_in = drive_sum;
                  phase_in = (count_ff != '0);
                  state_in = S_MUL1;
               end
            end
         end
         S_MUL1: begin
            state_in = S_MUL2;
         end
         S_MUL2: begin
            state_in = S_MUL3;
         end
         S_MUL3: begin
            k_in     = product;
            state_in = S_ADD;
         end
         S_ADD: begin
            volt_in = product + k_ff;
            if (phase_ff) begin
               count_in = count_ff - COUNT_W'(1);
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         volt_ff      <= '0;
         count_ff     <= '0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         volt_ff      <= volt_in;
         count_ff     <= count_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath holding registers and the result payload need no reset.
   always_ff @(posedge clock) begin
      drive_ff <= drive_in;
      k_ff     <= k_in;
      if (rsp_load) begin
         rsp_item_ff.membrane_voltage_out <= volt_ff;
         rsp_item_ff.refractory_active    <= (count_ff != '0);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // The multiply chain always runs through its three steps in order.
   a_mul_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL1) |=> (state_ff == S_MUL2) ##1 (state_ff == S_MUL3))
      else $error("multiply sequence out of order");

   // A spike never lowers the refractory count.
   a_spike_count: assert property (@(posedge clock) disable iff (reset)
      (accept && req_item.command == CMD_SPIKE) |=> (count_ff >= $past(count_ff)))
      else $error("refractory count dropped on spike");

   // A refractory timestep decrements the count exactly once.
   a_refr_dec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ADD && phase_ff) |=> (count_ff == $past(count_ff) - COUNT_W'(1)))
      else $error("refractory count not decremented");

   // Phase follows the count seen at acceptance.
   a_phase: assert property (@(posedge clock) disable iff (reset)
      (accept && req_item.command == CMD_TIMESTEP) |=> (phase_ff == ($past(count_ff) != '0)))
      else $error("phase select does not match refractory count");

   // A result is loaded only from the final step.
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff)) |-> ($past(state_ff) == S_DONE))
      else $error("result loaded outside final step");

endmodule

// ===== rtl/rnmu_csr.sv =====
// Configuration register file behind an APB-style port.
module rnmu_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [rnmu_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready,
   output rnmu_pkg::cfg_type          cfg
);
   import rnmu_pkg::*;

   word_type               regs_ff [REG_COUNT];
   logic [REG_IDX_W-1:0]   reg_idx;
   logic                   wr_en;

   assign reg_idx    = csr_paddr[ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = regs_ff[reg_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            regs_ff[i] <= REG_RESET[i];
         end
      end else if (wr_en) begin
         regs_ff[reg_idx] <= csr_pwdata;
      end
   end

   always_comb begin
      cfg.rest_bias          = regs_ff[REG_REST_BIAS];
      cfg.rest_inverse_gain  = regs_ff[REG_REST_INV];
      cfg.rest_decay         = regs_ff[REG_REST_DECAY];
      cfg.spike_bias         = regs_ff[REG_SPIKE_BIAS];
      cfg.spike_inverse_gain = regs_ff[REG_SPIKE_INV];
      cfg.spike_decay        = regs_ff[REG_SPIKE_DECAY];
      cfg.input_time_scale   = regs_ff[REG_TIME_SCALE];
      cfg.reset_voltage      = regs_ff[REG_RESET_VOLT];
   end

endmodule

// ===== rtl/rnmu_mul_unit.sv =====
// Shared s16.15 fixed-point multiplier with a registered, floor-truncated product.
module rnmu_mul_unit (
   input  logic                clock,
   input  rnmu_pkg::word_type  op_a,
   input  rnmu_pkg::word_type  op_b,
   output rnmu_pkg::word_type  product
);
   import rnmu_pkg::*;

   logic signed [2*WORD_W-1:0] full;
   word_type                   prod_ff;

   assign full = op_a * op_b;

   // arithmetic shift right by the fraction width, keep the low word
   always_ff @(posedge clock) begin
      prod_ff <= full[WORD_W+FRAC_W-1:FRAC_W];
   end

   assign product = prod_ff;

endmodule
